[design/str_pkg.sv]
// Shared types, constants and helpers for the trapezoidal stepper ramp.
package str_pkg;

  localparam int DELAY_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 24;
  localparam int RATE_W         = 16;
  localparam int LIMIT_W        = 23;
  localparam int CFG_DATA_W     = 23;
  localparam int CFG_IDX_W      = 3;
  localparam int POS_W          = 32;
  localparam int REM_W          = 32;
  localparam int ONE_STEP_DELAY = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_RATE  = 3'd0,
    REG_DECEL_RATE  = 3'd1,
    REG_FIRST_DELAY = 3'd2,
    REG_MIN_DELAY   = 3'd3,
    REG_SPEED_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_TRIVIAL,
    CMD_MUL_LIM,
    CMD_DIV_LIM,
    CMD_SAVE_LIM,
    CMD_MUL_TOP,
    CMD_DIV_TOP,
    CMD_START_FIN,
    CMD_DIV_RAMP,
    CMD_PULSE_FIN
  } cmd_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DISPATCH,
    C_DIV1,
    C_WAIT1,
    C_CHECK,
    C_WAIT2,
    C_START_FIN,
    C_PULSE_WAIT,
    C_PULSE_FIN
  } ctrl_state_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic   action;
    logic   mag_zero;
    logic   mag_one;
    logic   lim_le_top;
    logic   div_done;
    logic   out_free;
    phase_t phase;
  } status_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[design/str_req_if.sv]
// Input channel: start or pulse-done items.
interface str_req_if #(parameter int COUNT_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COUNT_BITS-1:0] step_count;

  modport source(output valid, action, step_count, input ready);
  modport sink(input valid, action, step_count, output ready);
endinterface

[design/str_rsp_if.sv]
// Result channel: next delay, position and motion status.
interface str_rsp_if #(parameter int DELAY_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [DELAY_BITS-1:0] next_delay;
  logic signed [31:0]    position;
  logic                  direction;
  logic [1:0]            phase;
  logic                  moving;
  logic                  output_off;

  modport source(output valid, next_delay, position, direction, phase, moving, output_off,
                 input ready);
  modport sink(input valid, next_delay, position, direction, phase, moving, output_off,
               output ready);
endinterface

[design/str_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module str_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);
  localparam int CNT_W = $clog2(DVD_W);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running && cnt == '0) begin
      running <= 1'b0;
      done    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CNT_W'(DVD_W - 1);
    end else if (running) begin
      quot <= {quot[DVD_W-2:0], fits};
      rem  <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      cnt  <= cnt - 1'b1;
    end
  end
endmodule

[design/str_ctrl.sv]
// Sequencer that steps the ramp datapath through start planning and pulse updates.
module str_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  str_pkg::status_t status,
  output str_pkg::ctrl_t   ctrl
);
  import str_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.cmd      = CMD_NONE;
    ctrl.in_ready = 1'b0;
    case (state)
      C_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (req_valid) begin
          ctrl.cmd   = CMD_LATCH;
          state_next = C_DISPATCH;
        end
      end
      C_DISPATCH: begin
        if (status.action) begin
          if (status.phase == PH_ACCEL || status.phase == PH_DECEL) begin
            ctrl.cmd   = CMD_DIV_RAMP;
            state_next = C_PULSE_WAIT;
          end else begin
            state_next = C_PULSE_FIN;
          end
        end else if (status.mag_zero || status.mag_one) begin
          if (status.out_free) begin
            ctrl.cmd   = CMD_TRIVIAL;
            state_next = C_IDLE;
          end
        end else begin
          ctrl.cmd   = CMD_MUL_LIM;
          state_next = C_DIV1;
        end
      end
      C_DIV1: begin
        ctrl.cmd   = CMD_DIV_LIM;
        state_next = C_WAIT1;
      end
      C_WAIT1: begin
        if (status.div_done) begin
          ctrl.cmd   = CMD_SAVE_LIM;
          state_next = C_CHECK;
        end
      end
      C_CHECK: begin
        if (status.lim_le_top) begin
          state_next = C_START_FIN;
        end else begin
          ctrl.cmd   = CMD_MUL_TOP;
          state_next = C_WAIT2;
        end
      end
      C_WAIT2: begin
        ctrl.cmd   = CMD_DIV_TOP;
        state_next = C_PULSE_WAIT;
      end
      C_PULSE_WAIT: begin
        if (status.div_done) begin
          state_next = status.action ? C_PULSE_FIN : C_START_FIN;
        end
      end
      C_START_FIN: begin
        if (status.out_free) begin
          ctrl.cmd   = CMD_START_FIN;
          state_next = C_IDLE;
        end
      end
      C_PULSE_FIN: begin
        if (status.out_free) begin
          ctrl.cmd   = CMD_PULSE_FIN;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end
endmodule

[design/str_dp.sv]
// Ramp datapath: configuration, motion state, multiplier, divider and result register.
module str_dp #(
  parameter int DELAY_BITS = str_pkg::DELAY_BITS_DEF,
  parameter int COUNT_BITS = str_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [str_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [str_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  str_pkg::ctrl_t                      ctrl,
  input  logic                                req_action,
  input  logic signed [COUNT_BITS-1:0]        req_step_count,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [DELAY_BITS-1:0]               rsp_next_delay,
  output logic signed [str_pkg::POS_W-1:0]    rsp_position,
  output logic                                rsp_direction,
  output logic [1:0]                          rsp_phase,
  output logic                                rsp_moving,
  output logic                                rsp_output_off,
  output str_pkg::status_t                    status
);
  import str_pkg::*;

  localparam int DB    = DELAY_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int NUM_W = imax(DB + 1, REM_W) + 1;
  localparam int DVD_W = imax(imax(CB + RATE_W, LIMIT_W + RATE_W), NUM_W);
  localparam int DVS_W = imax(CB + 2, RATE_W + 1);
  localparam int DCW   = imax(DB, RATE_W);
  localparam int LCW   = imax(CB, LIMIT_W);
  localparam logic [DB-1:0] ONE_DELAY = DB'(ONE_STEP_DELAY);

  logic [RATE_W-1:0]  accel_rate, decel_rate, first_delay, run_delay;
  logic [LIMIT_W-1:0] speed_limit;
  logic [RATE_W-1:0]  a_eff, d_eff;
  logic [LIMIT_W-1:0] top_eff;

  phase_t          phase, phase_next;
  logic            dir, dir_next, busy, busy_next;
  logic [DB-1:0]   cur, cur_next, last_ramp, last_ramp_next;
  logic [CB:0]     rc, rc_next, dc, dc_next;
  logic [CB-1:0]   dss, dss_next, sd, sd_next;
  logic [REM_W-1:0] rem, rem_next;
  logic [POS_W-1:0] pos, pos_next;
  logic            act, neg;
  logic [CB-1:0]   mag, lim, lim_next;
  logic [DVD_W-1:0] prod, prod_next;
  logic            load_out, off_next;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs, div_r;

  logic [CB:0]     rc_inc, dv;
  logic [CB+2:0]   n4;
  logic [DB-1:0]   q_lo, nd_div, fd;
  logic [CB-1:0]   sd_inc;
  logic [POS_W-1:0] pos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_rate  <= RATE_W'(1);
      decel_rate  <= RATE_W'(1);
      first_delay <= RATE_W'(ONE_STEP_DELAY);
      run_delay   <= RATE_W'(100);
      speed_limit <= LIMIT_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_ACCEL_RATE:  accel_rate  <= cfg_wdata[RATE_W-1:0];
        REG_DECEL_RATE:  decel_rate  <= cfg_wdata[RATE_W-1:0];
        REG_FIRST_DELAY: first_delay <= cfg_wdata[RATE_W-1:0];
        REG_MIN_DELAY:   run_delay   <= cfg_wdata[RATE_W-1:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_eff   = (accel_rate == '0) ? RATE_W'(1) : accel_rate;
  assign d_eff   = (decel_rate == '0) ? RATE_W'(1) : decel_rate;
  assign top_eff = (speed_limit == '0) ? LIMIT_W'(1) : speed_limit;

  str_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign rc_inc  = rc + 1'b1;
  assign n4      = {rc_inc, 2'b01};
  assign q_lo    = div_q[DB-1:0];
  assign nd_div  = rc_inc[CB] ? cur + q_lo : cur - q_lo;
  assign sd_inc  = sd + 1'b1;
  assign pos_inc = dir ? pos - 1'b1 : pos + 1'b1;
  assign fd      = DB'(first_delay);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod;
    div_dvs   = DVS_W'(a_eff) + DVS_W'(d_eff);
    case (ctrl.cmd)
      CMD_DIV_LIM: div_start = 1'b1;
      CMD_DIV_TOP: begin
        div_start = 1'b1;
        div_dvs   = DVS_W'(d_eff);
      end
      CMD_DIV_RAMP: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({cur, 1'b0}) + DVD_W'(rem);
        div_dvs   = DVS_W'(n4[CB+2] ? -n4 : n4);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (status.lim_le_top) begin
      dv = {1'b0, lim} - {1'b0, mag};
    end else begin
      dv = -div_q[CB:0];
    end
    if ((status.lim_le_top && lim == mag) || (!status.lim_le_top && div_q == '0)) begin
      dv = '1;
    end
  end

  always_comb begin
    phase_next     = phase;
    dir_next       = dir;
    busy_next      = busy;
    cur_next       = cur;
    last_ramp_next = last_ramp;
    rc_next        = rc;
    dc_next        = dc;
    dss_next       = dss;
    sd_next        = sd;
    rem_next       = rem;
    pos_next       = pos;
    lim_next       = lim;
    prod_next      = prod;
    load_out       = 1'b0;
    off_next       = 1'b0;
    case (ctrl.cmd)
      CMD_MUL_LIM: prod_next = DVD_W'(mag) * DVD_W'(d_eff);
      CMD_MUL_TOP: prod_next = DVD_W'(top_eff) * DVD_W'(a_eff);
      CMD_SAVE_LIM: lim_next = (div_q[CB-1:0] == '0) ? CB'(1) : div_q[CB-1:0];
      CMD_TRIVIAL: begin
        dir_next  = neg;
        busy_next = 1'b1;
        load_out  = 1'b1;
        if (status.mag_one) begin
          rc_next    = '1;
          phase_next = PH_DECEL;
          cur_next   = ONE_DELAY;
        end
      end
      CMD_START_FIN: begin
        dir_next  = neg;
        busy_next = 1'b1;
        load_out  = 1'b1;
        dc_next   = dv;
        dss_next  = mag + dv[CB-1:0];
        rc_next   = '0;
        if (DCW'(fd) <= DCW'(run_delay)) begin
          cur_next   = DB'(run_delay);
          phase_next = PH_RUN;
        end else begin
          cur_next   = fd;
          phase_next = PH_ACCEL;
        end
      end
      CMD_PULSE_FIN: begin
        load_out = 1'b1;
        case (phase)
          PH_STOP: begin
            sd_next   = '0;
            rem_next  = '0;
            busy_next = 1'b0;
            off_next  = 1'b1;
            cur_next  = '0;
          end
          PH_ACCEL: begin
            sd_next  = sd_inc;
            pos_next = pos_inc;
            rc_next  = rc_inc;
            rem_next = REM_W'(div_r);
            cur_next = nd_div;
            if (sd_inc >= dss) begin
              rc_next    = dc;
              phase_next = PH_DECEL;
            end else if (DCW'(nd_div) <= DCW'(run_delay)) begin
              last_ramp_next = nd_div;
              cur_next       = DB'(run_delay);
              rem_next       = '0;
              phase_next     = PH_RUN;
            end
          end
          PH_RUN: begin
            sd_next  = sd_inc;
            pos_next = pos_inc;
            cur_next = DB'(run_delay);
            if (sd_inc >= dss) begin
              rc_next    = dc;
              cur_next   = last_ramp;
              phase_next = PH_DECEL;
            end
          end
          default: begin
            sd_next  = sd_inc;
            pos_next = pos_inc;
            rc_next  = rc_inc;
            rem_next = REM_W'(div_r);
            cur_next = nd_div;
            if (!rc_inc[CB]) begin
              phase_next = PH_STOP;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STOP;
      dir       <= 1'b0;
      busy      <= 1'b0;
      cur       <= '0;
      last_ramp <= '0;
      rc        <= '0;
      dc        <= '0;
      dss       <= '0;
      sd        <= '0;
      rem       <= '0;
      pos       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      dir       <= dir_next;
      busy      <= busy_next;
      cur       <= cur_next;
      last_ramp <= last_ramp_next;
      rc        <= rc_next;
      dc        <= dc_next;
      dss       <= dss_next;
      sd        <= sd_next;
      rem       <= rem_next;
      pos       <= pos_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim  <= lim_next;
    prod <= prod_next;
    if (ctrl.cmd == CMD_LATCH) begin
      act <= req_action;
      neg <= req_step_count[CB-1];
      mag <= req_step_count[CB-1] ? CB'(-req_step_count) : CB'(req_step_count);
    end
    if (load_out) begin
      rsp_next_delay <= cur_next;
      rsp_position   <= pos_next;
      rsp_direction  <= dir_next;
      rsp_phase      <= phase_next;
      rsp_moving     <= busy_next;
      rsp_output_off <= off_next;
    end
  end

  assign status.action     = act;
  assign status.mag_zero   = (mag == '0);
  assign status.mag_one    = (mag == CB'(1));
  assign status.lim_le_top = LCW'(lim) <= LCW'(top_eff);
  assign status.div_done   = div_done;
  assign status.out_free   = !rsp_valid || rsp_ready;
  assign status.phase      = phase;
endmodule

[design/stepper_trapezoid_ramp.sv]
// Top level of the trapezoidal stepper ramp: sequencer, datapath and channel ports.
// A pulse item in the stop or run phase is finished without a division once it is taken.
// A pulse item in accelerate or decelerate waits for the bit-serial divider. A start
// item runs two divisions when the speed limit applies, one otherwise, and none for
// zero or one step; a held result stalls any item until the receiver takes it.
// Synchronous reset stops the axis, clears position and state and loads default config.
module stepper_trapezoid_ramp #(
  parameter int DELAY_BITS = str_pkg::DELAY_BITS_DEF,
  parameter int COUNT_BITS = str_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [str_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [str_pkg::CFG_DATA_W-1:0] cfg_wdata,
  str_req_if.sink                        req,
  str_rsp_if.source                      rsp
);
  import str_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  str_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .status(status), .ctrl(ctrl)
  );

  assign req.ready = ctrl.in_ready;

  str_dp #(.DELAY_BITS(DELAY_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .ctrl(ctrl),
    .req_action(req.action), .req_step_count(req.step_count),
    .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
    .rsp_next_delay(rsp.next_delay), .rsp_position(rsp.position),
    .rsp_direction(rsp.direction), .rsp_phase(rsp.phase),
    .rsp_moving(rsp.moving), .rsp_output_off(rsp.output_off),
    .status(status)
  );
endmodule

[dv/testbench.sv]
// Self-checking testbench for the trapezoidal stepper ramp: directed table, a direct run, then random moves.
`timescale 1ns / 100ps

module testbench;
  import str_pkg::*;

  localparam int DW = 16;
  localparam int CW = 24;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [DW-1:0] next_delay;
    logic [31:0]   position;
    logic          direction;
    phase_t        phase;
    logic          moving;
    logic          output_off;
  } motion_t;

  typedef struct {
    logic          action;
    logic [CW-1:0] steps;
    logic          has_fixed;
    motion_t       fixed;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  str_req_if #(.COUNT_BITS(CW)) req ();
  str_rsp_if #(.DELAY_BITS(DW)) rsp ();

  stepper_trapezoid_ramp i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  // Predicted axis state and configuration.
  logic [15:0] m_accel, m_decel, m_first, m_min;
  logic [22:0] m_limit;
  phase_t      m_phase;
  logic        m_dir, m_busy;
  logic [DW-1:0] m_delay, m_last_ramp;
  logic [CW:0] m_ramp, m_decel_cnt;
  logic [CW-1:0] m_decel_start, m_done;
  logic [31:0] m_rem, m_pos;

  motion_t motion_queue[$];
  int  errors;
  int  idle_cycles;
  logic done_driving;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void axis_reset();
    m_accel = 1; m_decel = 1; m_first = 1000; m_min = 100; m_limit = 1;
    m_phase = PH_STOP; m_dir = 0; m_busy = 0; m_delay = 0; m_last_ramp = 0;
    m_ramp = 0; m_decel_cnt = 0; m_decel_start = 0; m_done = 0; m_rem = 0; m_pos = 0;
  endfunction

  function automatic void one_step();
    m_done = m_done + 1;
    m_pos = m_dir ? m_pos - 1 : m_pos + 1;
  endfunction

  function automatic logic [DW-1:0] ramp_delay();
    longint n, dv, num, mag, q;
    n = longint'($signed(m_ramp));
    dv = 4 * n + 1;
    num = 2 * longint'(m_delay) + longint'(m_rem);
    mag = dv < 0 ? -dv : dv;
    q = num / mag;
    m_rem = 32'(num % mag);
    return dv < 0 ? DW'(longint'(m_delay) + q) : DW'(longint'(m_delay) - q);
  endfunction

  function automatic motion_t predict_motion(logic action, logic [CW-1:0] steps);
    motion_t r;
    logic off;
    logic [DW-1:0] nd;
    longint s, mag, a, d, top, lim, dv;
    off = 0;
    if (!action) begin
      s = longint'($signed(steps));
      m_dir = s < 0;
      mag = s < 0 ? -s : s;
      if (mag == 1) begin
        m_ramp = '1;
        m_phase = PH_DECEL;
        m_delay = DW'(ONE_STEP_DELAY);
      end else if (mag != 0) begin
        a = m_accel == 0 ? 1 : m_accel;
        d = m_decel == 0 ? 1 : m_decel;
        top = m_limit == 0 ? 1 : m_limit;
        lim = mag * d / (a + d);
        if (lim == 0) lim = 1;
        if (lim <= top) dv = lim - mag;
        else dv = -(top * a / d);
        if (dv == 0) dv = -1;
        m_decel_cnt = (CW+1)'(dv);
        m_decel_start = CW'(mag + dv);
        m_delay = m_first;
        if (m_delay <= m_min) begin
          m_delay = m_min;
          m_phase = PH_RUN;
        end else begin
          m_phase = PH_ACCEL;
        end
        m_ramp = 0;
      end
      m_busy = 1;
    end else begin
      nd = 0;
      case (m_phase)
        PH_STOP: begin
          m_done = 0; m_rem = 0; m_busy = 0; off = 1;
        end
        PH_ACCEL: begin
          one_step();
          m_ramp = m_ramp + 1;
          nd = ramp_delay();
          if (m_done >= m_decel_start) begin
            m_ramp = m_decel_cnt;
            m_phase = PH_DECEL;
          end else if (nd <= m_min) begin
            m_last_ramp = nd;
            nd = m_min;
            m_rem = 0;
            m_phase = PH_RUN;
          end
        end
        PH_RUN: begin
          one_step();
          nd = m_min;
          if (m_done >= m_decel_start) begin
            m_ramp = m_decel_cnt;
            nd = m_last_ramp;
            m_phase = PH_DECEL;
          end
        end
        default: begin
          one_step();
          m_ramp = m_ramp + 1;
          nd = ramp_delay();
          if (!m_ramp[CW]) m_phase = PH_STOP;
        end
      endcase
      m_delay = nd;
    end
    r.next_delay = m_delay;
    r.position = m_pos;
    r.direction = m_dir;
    r.phase = m_phase;
    r.moving = m_busy;
    r.output_off = off;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      REG_ACCEL_RATE:  m_accel = val[15:0];
      REG_DECEL_RATE:  m_decel = val[15:0];
      REG_FIRST_DELAY: m_first = val[15:0];
      REG_MIN_DELAY:   m_min = val[15:0];
      default:         m_limit = val;
    endcase
  endtask

  task automatic send_item(logic action, logic [CW-1:0] steps, logic has_fixed, motion_t fixed);
    motion_t p;
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.action <= action;
    req.step_count <= steps;
    do @(posedge clk); while (!req.ready);
    p = predict_motion(action, steps);
    if (has_fixed && p != fixed) begin
      $display("%0t table row disagrees: expected %h actual %h", $time, fixed, p);
      errors++;
    end
    motion_queue.push_back(p);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (motion_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_ACCEL_RATE, extreme ? ($urandom_range(0, 1) ? 1 : 65535) : $urandom_range(1, 2000));
    write_reg(REG_DECEL_RATE, extreme ? ($urandom_range(0, 1) ? 1 : 65535) : $urandom_range(1, 2000));
    write_reg(REG_FIRST_DELAY, extreme ? ($urandom_range(0, 1) ? 1 : 65535) :
              $urandom_range(200, 20000));
    write_reg(REG_MIN_DELAY, extreme ? ($urandom_range(0, 1) ? 1 : 65535) :
              $urandom_range(1, 400));
    write_reg(REG_SPEED_LIMIT, extreme ? ($urandom_range(0, 1) ? 0 : 23'h7FFFFF) :
              $urandom_range(0, 40));
  endtask

  function automatic motion_t mk(int dl, int pos, bit dir, phase_t ph, bit mv, bit off);
    motion_t r;
    r.next_delay = dl; r.position = pos; r.direction = dir;
    r.phase = ph; r.moving = mv; r.output_off = off;
    return r;
  endfunction

  always @(posedge clk) begin
    motion_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (motion_queue.size() == 0) begin
        $display("%0t unexpected item: actual %h", $time,
                 {rsp.next_delay, rsp.position, rsp.direction, rsp.phase, rsp.moving,
                  rsp.output_off});
        errors++;
      end else begin
        e = motion_queue.pop_front();
        if (rsp.next_delay !== e.next_delay) begin
          $display("%0t next_delay: expected %0d actual %0d", $time, e.next_delay,
                   rsp.next_delay);
          errors++;
        end
        if (rsp.position !== e.position) begin
          $display("%0t position: expected %0d actual %0d", $time, $signed(e.position),
                   rsp.position);
          errors++;
        end
        if (rsp.direction !== e.direction) begin
          $display("%0t direction: expected %0d actual %0d", $time, e.direction,
                   rsp.direction);
          errors++;
        end
        if (rsp.phase !== e.phase) begin
          $display("%0t phase: expected %0d actual %0d", $time, e.phase, rsp.phase);
          errors++;
        end
        if (rsp.moving !== e.moving) begin
          $display("%0t moving: expected %0d actual %0d", $time, e.moving, rsp.moving);
          errors++;
        end
        if (rsp.output_off !== e.output_off) begin
          $display("%0t output_off: expected %0d actual %0d", $time, e.output_off,
                   rsp.output_off);
          errors++;
        end
      end
    end
  end

  // The receiver holds ready low for a random stretch before each item, or not at all.
  initial begin
    int gap;
    rsp.ready = 0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        rsp.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || done_driving || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int steps, len, k;
    motion_t none;
    none = '0;
    errors = 0;
    done_driving = 0;
    idle_cycles = 0;
    rst = 1;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    req.valid = 0; req.action = 0; req.step_count = 0;
    axis_reset();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back('{1, 24'd0, 1, mk(0, 0, 0, PH_STOP, 0, 1)});
    rows.push_back('{0, 24'd0, 1, mk(0, 0, 0, PH_STOP, 1, 0)});
    rows.push_back('{1, 24'd0, 1, mk(0, 0, 0, PH_STOP, 0, 1)});
    rows.push_back('{0, 24'd1, 1, mk(1000, 0, 0, PH_DECEL, 1, 0)});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{0, 24'hFFFFFF, 1, mk(1000, 1, 1, PH_DECEL, 1, 0)});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{0, 24'd6, 0, none});
    for (int i = 0; i < 7; i++) rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{0, 24'hFFFFFB, 0, none});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{0, 24'h7FFFFF, 0, none});
    rows.push_back('{1, 24'd0, 0, none});
    rows.push_back('{0, 24'h800000, 0, none});
    rows.push_back('{1, 24'd0, 0, none});
    foreach (rows[i]) send_item(rows[i].action, rows[i].steps, rows[i].has_fixed, rows[i].fixed);
    drain();

    // Direct run: first delay at or below the top-speed delay.
    write_reg(REG_MIN_DELAY, 2000);
    write_reg(REG_SPEED_LIMIT, 3);
    send_item(0, 24'd9, 0, none);
    repeat (11) send_item(1, 0, 0, none);
    drain();

    k = 0;
    for (int phase_no = 0; k < 1790; phase_no++) begin
      random_config(phase_no % 5 == 4);
      for (int m = 0; m < 8 && k < 1790; m++) begin
        case ($urandom_range(0, 9))
          0: steps = $urandom_range(0, 1);
          1: steps = $urandom_range(0, 1) ? 8388607 : -8388608;
          default: steps = $urandom_range(2, 60);
        endcase
        if ($urandom_range(0, 1) && steps > 0) steps = -steps;
        send_item(0, CW'(steps), 0, none);
        k++;
        len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 20) : 80;
        for (int p = 0; p < len && m_phase != PH_STOP; p++) begin
          send_item(1, CW'($urandom), 0, none);
          k++;
        end
        if ($urandom_range(0, 1)) begin
          send_item(1, CW'($urandom), 0, none);
          k++;
        end
      end
      drain();
    end
    done_driving = 1;
    drain();
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

[filelist.f]
design/str_pkg.sv
design/str_req_if.sv
design/str_rsp_if.sv
design/str_div.sv
design/str_ctrl.sv
design/str_dp.sv
design/stepper_trapezoid_ramp.sv
dv/testbench.sv
